// File: rtl/assert_macros.svh
// Assertion macros shared by the block's checking code.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RAB_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define RAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent at the same edge.
`define RAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/rab_pkg.sv
// Types and constants of the running average background block.
package rab_pkg;

  localparam int unsigned ALPHA_W    = 17;
  localparam int unsigned ALPHA_FRAC = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd3277;
  localparam int unsigned FRAME_RESET = 307200;

  localparam int unsigned CFG_DW = 21;
  localparam int unsigned CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_ALPHA = 1'b0;
  localparam logic [CFG_IW-1:0] REG_FRAME = 1'b1;

  typedef enum logic [1:0] {
    OP_SKIP,
    OP_IGNORE,
    OP_LOAD,
    OP_BLEND
  } op_t;

  typedef struct packed {
    op_t  op;
    logic ready;
  } rab_ctl_t;

  typedef struct packed {
    logic initialized;
    logic loading;
  } rab_stat_t;

endpackage

// File: rtl/rab_mem.sv
// Background store: one write port, one read port, registered read data.
module rab_mem import rab_pkg::*; #(
  parameter int unsigned DEPTH = 1048576,
  parameter int unsigned WIDTH = 24,
  parameter int unsigned AW    = 20
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write; the update stage forwards the newest value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/rab_ctrl.sv
// Configuration registers and raster position sequencing at request accept.
module rab_ctrl import rab_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned AW         = 20,
  parameter int unsigned PW         = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_IW-1:0]  cfg_index,
  input  logic [CFG_DW-1:0]  cfg_data,
  input  logic               acc,
  input  logic               first,
  output rab_ctl_t           ctl,
  output logic [AW-1:0]      addr,
  output logic [ALPHA_W-1:0] alpha,
  output rab_stat_t          stat
);

  localparam int unsigned LW = (PW > CFG_DW) ? PW : CFG_DW;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_PIXELS);
  localparam logic [PW-1:0] LIMIT_RST =
    (FRAME_RESET > MAX_PIXELS) ? PW'(MAX_PIXELS) : PW'(FRAME_RESET);

  logic [ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [PW-1:0]      limit_r, limit_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               init_r, init_nxt;
  logic               load_r, load_nxt;

  logic [LW-1:0] fv_ext;
  logic [PW-1:0] pos_eff, pos_inc;
  logic          load_eff, ign;
  op_t           op;

  // clamp at write time
  assign fv_ext = LW'(cfg_data);

  always_comb begin
    alpha_nxt = alpha_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHA: begin
          alpha_nxt = (cfg_data[ALPHA_W-1:0] > ALPHA_ONE) ? ALPHA_ONE
                                                            : cfg_data[ALPHA_W-1:0];
        end
        REG_FRAME: begin
          limit_nxt = (fv_ext > MAX_L) ? PW'(MAX_L) : PW'(fv_ext);
        end
        default: begin
          alpha_nxt = alpha_r;
        end
      endcase
    end
  end

  assign pos_eff  = first ? '0 : pos_r;
  assign load_eff = load_r | (first & ~init_r);
  assign ign      = (pos_eff >= limit_r);
  assign pos_inc  = pos_eff + 1'b1;

  always_comb begin
    if (ign) begin
      op = OP_IGNORE;
    end else if (init_r) begin
      op = OP_BLEND;
    end else if (load_eff) begin
      op = OP_LOAD;
    end else begin
      op = OP_SKIP;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    init_nxt = init_r;
    load_nxt = load_r;
    if (acc) begin
      load_nxt = load_eff;
      unique case (op)
        OP_BLEND: pos_nxt = pos_inc;
        OP_LOAD: begin
          pos_nxt = pos_inc;
          if (pos_inc == limit_r) begin
            init_nxt = 1'b1;
            load_nxt = 1'b0;
          end
        end
        OP_IGNORE, OP_SKIP: pos_nxt = pos_eff;
        default: pos_nxt = pos_eff;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
      limit_r <= LIMIT_RST;
      pos_r   <= '0;
      init_r  <= 1'b0;
      load_r  <= 1'b0;
    end else begin
      alpha_r <= alpha_nxt;
      limit_r <= limit_nxt;
      pos_r   <= pos_nxt;
      init_r  <= init_nxt;
      load_r  <= load_nxt;
    end
  end

  assign ctl.op    = op;
  assign ctl.ready = init_nxt;
  assign addr      = pos_eff[AW-1:0];
  assign alpha     = alpha_r;
  assign stat.initialized = init_r;
  assign stat.loading     = load_r;

endmodule

// File: rtl/rab_upd.sv
// Update stage: forwarding, fixed-point blend, write-back and result forming.
module rab_upd import rab_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned AW        = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  rab_ctl_t           ctl,
  input  logic [AW-1:0]      addr,
  input  logic [7:0]         pixel,
  input  logic [ALPHA_W-1:0] alpha,
  input  logic               go,
  input  logic [8+FRAC_BITS-1:0] rd_data,
  output logic               s1_valid,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [8+FRAC_BITS-1:0] wr_data,
  output logic [7:0]         res_bg,
  output logic               res_ign,
  output logic               res_ready
);

  localparam int unsigned BW = 8 + FRAC_BITS;
  localparam int unsigned MW = BW + ALPHA_W + 2;

  logic          s1_valid_r, s1_valid_nxt;
  rab_ctl_t      s1_ctl_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    s1_pix_r;

  logic          lw_valid_r;
  logic [AW-1:0] lw_addr_r;
  logic [BW-1:0] lw_data_r;

  logic [BW-1:0]        bg, target, nv;
  logic signed [BW:0]   diff;
  logic signed [MW-1:0] prod, delta, nv_full;
  logic [BW:0]          rnd;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      lw_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (wr_en) begin
        lw_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_ctl_r  <= ctl;
      s1_addr_r <= addr;
      s1_pix_r  <= pixel;
    end
    if (wr_en) begin
      lw_addr_r <= wr_addr;
      lw_data_r <= wr_data;
    end
  end

  // newest value of the entry: last write wins over the memory read
  assign bg     = (lw_valid_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : rd_data;
  assign target = {s1_pix_r, {FRAC_BITS{1'b0}}};

  // bg + alpha*(target-bg), rounded half up at the alpha point
  assign diff    = $signed({1'b0, target}) - $signed({1'b0, bg});
  assign prod    = MW'($signed({1'b0, alpha})) * MW'(diff);
  assign delta   = (prod + MW'(1 << (ALPHA_FRAC - 1))) >>> ALPHA_FRAC;
  assign nv_full = $signed(MW'(bg)) + delta;
  assign nv      = nv_full[BW-1:0];

  assign rnd = {1'b0, nv} + (BW+1)'(1 << (FRAC_BITS - 1));

  assign wr_en   = go && ((s1_ctl_r.op == OP_BLEND) || (s1_ctl_r.op == OP_LOAD));
  assign wr_addr = s1_addr_r;
  assign wr_data = (s1_ctl_r.op == OP_LOAD) ? target : nv;

  always_comb begin
    case (s1_ctl_r.op)
      OP_BLEND: res_bg = (rnd[BW:FRAC_BITS] > 9'd255) ? 8'd255 : rnd[FRAC_BITS+7:FRAC_BITS];
      OP_LOAD:  res_bg = s1_pix_r;
      default:  res_bg = 8'd0;
    endcase
  end

  assign res_ign   = (s1_ctl_r.op == OP_IGNORE);
  assign res_ready = s1_ctl_r.ready;
  assign s1_valid  = s1_valid_r;

endmodule

// File: rtl/running_average_background.sv
// Running average background model: top level with request channels.
//
// Input requests carry one gray pixel (in_tdata) in raster order; in_tuser
// marks the first pixel of a frame. Each request yields exactly one result:
// the updated background level on out_tdata, with the ignored and
// model_ready flags on out_tuser.
// The first complete frame after reset is copied into the store; later
// frames blend into it with weight alpha_q16 (cfg index 0). The frame size
// is cfg index 1. Write configuration only while the block is idle.
// A request is registered into the update stage with its store read, then
// its result into the output register. Throughput: one pixel per clock
// unless the receiver stalls. Each pixel is a read-modify-write of its own
// store entry; a repeat of the entry just written is served from the
// write-back register, so short frames never stall.
// Reset clears the position, the ready and loading flags and the valid
// bits; the store itself is not cleared and gets no sweep.
// When the receiver stalls the result holds in the output register, one
// more request may sit in the update stage, then in_tready drops.
module running_average_background import rab_pkg::*; #(
  parameter int unsigned MAX_PIXELS = 1048576,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  // input requests
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel
  input  logic              in_tuser,   // [0] first_of_frame
  // results
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] background
  output logic [1:0]        out_tuser   // [0] ignored, [1] model_ready
);

`include "assert_macros.svh"

  localparam int unsigned AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned BW = 8 + FRAC_BITS;

  logic               acc, s1_go, s1_valid;
  rab_ctl_t           ctl;
  rab_stat_t          stat;
  logic [AW-1:0]      addr;
  logic [ALPHA_W-1:0] alpha;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [BW-1:0] wr_data, rd_data;

  logic [7:0] res_bg;
  logic       res_ign, res_ready;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_bg_r;
  logic [1:0] out_user_r;

  // update stage moves on when the output register is free or being drained
  assign s1_go     = s1_valid && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid || s1_go;
  assign acc       = in_tvalid && in_tready;

  rab_ctrl #(
    .MAX_PIXELS (MAX_PIXELS),
    .AW         (AW),
    .PW         (PW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .first     (in_tuser),
    .ctl       (ctl),
    .addr      (addr),
    .alpha     (alpha),
    .stat      (stat)
  );

  // only blends need the stored value
  rab_mem #(
    .DEPTH (MAX_PIXELS),
    .WIDTH (BW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (acc && (ctl.op == OP_BLEND)),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  rab_upd #(
    .FRAC_BITS (FRAC_BITS),
    .AW        (AW)
  ) u_upd (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .ctl       (ctl),
    .addr      (addr),
    .pixel     (in_tdata),
    .alpha     (alpha),
    .go        (s1_go),
    .rd_data   (rd_data),
    .s1_valid  (s1_valid),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_bg    (res_bg),
    .res_ign   (res_ign),
    .res_ready (res_ready)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_bg_r   <= res_bg;
      out_user_r <= {res_ready, res_ign};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_bg_r;
  assign out_tuser  = out_user_r;

  `RAB_ASSERT_NEXT(a_ready_sticky, stat.initialized, stat.initialized, "model ready fell")
  `RAB_ASSERT(a_ready_not_loading, !(stat.initialized && stat.loading), "ready while loading")
  `RAB_ASSERT_IMPL(a_stall_blocks_input, s1_valid && !s1_go, !in_tready, "accept during stall")
  `RAB_ASSERT_IMPL(a_ignored_zero, out_tvalid && out_tuser[0], out_tdata == 8'd0, "ignored non-zero")

endmodule

// File: dv/running_average_background_tb.sv
// Self-checking stream testbench for the running average background block.
module running_average_background_tb import rab_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PIX     = 1048576;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned LOAD_PIXELS = 64;      // size of the frame that fills the store
  localparam int unsigned RAND_ITEMS  = 1700;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One input request and one expected result, as the testbench holds them.
  typedef struct packed {
    logic [7:0] pix;
    logic       sof;
  } pixel_req_t;

  typedef struct packed {
    logic [7:0] background;
    logic       ignored;
    logic       ready;
  } bg_result_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // Block inputs, all known from time zero
  logic              cfg_we    = 1'b0;
  logic [CFG_IW-1:0] cfg_index = REG_ALPHA;
  logic [CFG_DW-1:0] cfg_data  = '0;
  logic              in_tvalid = 1'b0;
  logic [7:0]        in_tdata  = '0;   // [7:0] pixel
  logic              in_tuser  = 1'b0; // [0] first_of_frame
  logic              out_tready = 1'b0;

  // Block outputs
  logic              in_tready;
  logic              out_tvalid;
  logic [7:0]        out_tdata;        // [7:0] background
  logic [1:0]        out_tuser;        // [0] ignored, [1] model_ready

  running_average_background dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------
  // Background predictor: own copy of the store, scan position, flags and
  // registers. Store entries are Q8.16; unwritten entries are simply absent.
  // ---------------------------------------------------------------------
  logic [23:0]        bg_store [int unsigned];
  int unsigned        scan_pos      = 0;
  logic               model_init    = 1'b0;
  logic               model_loading = 1'b0;
  logic [ALPHA_W-1:0] alpha_set     = ALPHA_RESET;
  logic [CFG_DW-1:0]  frame_set     = CFG_DW'(FRAME_RESET);
  int unsigned        written_top   = 0;   // entries 0 .. written_top-1 hold data

  pixel_req_t pixel_queue [$];   // requests waiting for the driver
  bg_result_t bg_expected [$];   // backgrounds predicted, oldest first

  int unsigned sent_n  = 0;      // requests queued
  int unsigned taken_n = 0;      // requests accepted by the block
  int unsigned error_n = 0;
  int unsigned cycle_n = 0;

  function automatic void predict_background(input logic [7:0] pix, input logic sof);
    bg_result_t         r;
    int unsigned        lim;
    logic [23:0]        old_bg;
    logic [23:0]        new_bg;
    logic [ALPHA_W-1:0] a;
    logic [63:0]        acc;
    logic [63:0]        level;
    r   = '0;
    lim = (frame_set > MAX_PIX) ? MAX_PIX : int'(frame_set);
    // a start mark rewinds; before the store is ready it (re)starts loading
    if (sof) begin
      scan_pos = 0;
      if (!model_init) model_loading = 1'b1;
    end
    if (scan_pos >= lim) begin
      r.ignored = 1'b1;                 // past the frame: no state change
    end else if (model_init) begin
      if (bg_store.exists(scan_pos)) begin
        old_bg = bg_store[scan_pos];
      end else begin
        old_bg = '0;
        error_n++;
        $display("%0t: stimulus reached unwritten store entry %0d", $time, scan_pos);
      end
      a      = (alpha_set > ALPHA_ONE) ? ALPHA_ONE : alpha_set;
      acc    = (64'(ALPHA_ONE) - 64'(a)) * 64'(old_bg)
             + 64'(a) * (64'(pix) << FRAC) + 64'd32768;
      new_bg = acc[39:16];
      bg_store[scan_pos] = new_bg;
      level  = (64'(new_bg) + 64'd32768) >> FRAC;
      r.background = (level > 64'd255) ? 8'hFF : level[7:0];
      scan_pos++;
    end else if (model_loading) begin
      bg_store[scan_pos] = {pix, 16'h0000};
      if (scan_pos + 1 > written_top) written_top = scan_pos + 1;
      r.background = pix;
      scan_pos++;
      if (scan_pos == lim) begin
        model_init    = 1'b1;
        model_loading = 1'b0;
      end
    end
    // pixels before any start mark fall through: zero, not ignored
    r.ready = model_init;
    bg_expected.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: feeds requests from pixel_queue in bursts with random gaps.
  // Prediction happens at the edge where the request is accepted.
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  pixel_req_t  drv_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_background(in_tdata, in_tuser);
        taken_n++;
      end
      // free slot: either idle or the current request just went in
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pixel_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          drv_req = pixel_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= drv_req.pix;
          in_tuser  <= drv_req.sof;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest prediction and
  // stalls the result channel on a pattern that changes mode now and then.
  // ---------------------------------------------------------------------
  int unsigned stall_mode  = 0;
  int unsigned stall_timer = 0;
  logic        take_next;
  bg_result_t  mon_exp;

  task automatic note_mismatch(input string field, input int unsigned exp_v,
                               input int unsigned got_v);
    error_n++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (bg_expected.size() == 0) begin
          error_n++;
          $display("%0t: result with no request outstanding, expected none, got bg=%0d flags=%b",
                   $time, out_tdata, out_tuser);
        end else begin
          mon_exp = bg_expected.pop_front();
          if (out_tdata !== mon_exp.background)
            note_mismatch("background", mon_exp.background, out_tdata);
          if (out_tuser[0] !== mon_exp.ignored)
            note_mismatch("ignored", mon_exp.ignored, out_tuser[0]);
          if (out_tuser[1] !== mon_exp.ready)
            note_mismatch("model_ready", mon_exp.ready, out_tuser[1]);
        end
      end
      if (stall_timer == 0) begin
        stall_mode  = $urandom_range(0, 3);
        stall_timer = $urandom_range(20, 120);
      end else begin
        stall_timer--;
      end
      case (stall_mode)
        0:       take_next = 1'b1;                           // no back-pressure
        1:       take_next = ($urandom_range(0, 3) != 0);    // light random
        2:       take_next = ((stall_timer % 8) < 5);        // periodic
        default: take_next = ($urandom_range(0, 2) == 0);    // heavy
      endcase
      out_tready <= take_next;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("FAIL running_average_background");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_pixel(input logic [7:0] pix, input logic sof);
    pixel_queue.push_back('{pix: pix, sof: sof});
    sent_n++;
  endtask

  // Idle: every request taken and answered, and the pipe left to empty
  task automatic wait_idle();
    while (taken_n != sent_n || bg_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only called while idle, so the copy can follow at once
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_ALPHA) alpha_set = val[ALPHA_W-1:0];
    else frame_set = val;
  endtask

  function automatic logic [7:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CFG_DW-1:0] pick_alpha();
    logic [CFG_DW-1:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = CFG_DW'(ALPHA_ONE);
      2: begin
        // above one, with junk in the bits beyond the register
        v = CFG_DW'($urandom_range(65537, 131071));
        v[CFG_DW-1:ALPHA_W] = (CFG_DW-ALPHA_W)'($urandom_range(0, 15));
      end
      3: v = CFG_DW'(1);
      4: v = CFG_DW'(65535);
      default: v = CFG_DW'($urandom_range(1, 65535));
    endcase
    return v;
  endfunction

  // Never beyond what the store holds once it is ready
  function automatic logic [CFG_DW-1:0] pick_frame();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6)      return CFG_DW'($urandom_range(1, 8));
    else if (r < 9) return CFG_DW'($urandom_range(9, 24));
    else            return CFG_DW'($urandom_range(25, written_top));
  endfunction

  // One frame of random content: mostly whole, some short, long or stray
  task automatic gen_frame(input int unsigned n);
    int unsigned len;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 6)) push_pixel(rand_pixel(), 1'b0);
    end else begin
      if (kind == 7 && n > 1)  len = $urandom_range(1, n - 1);
      else if (kind == 8)      len = n + $urandom_range(1, 4);
      else                     len = n;
      push_pixel(rand_pixel(), 1'b1);
      repeat (len - 1) push_pixel(rand_pixel(), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  int unsigned rand_base;
  int unsigned abort_n;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Before any start mark nothing is stored: zero back, not ignored
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hFF, 1'b0);
    wait_idle();

    // Frame size zero: everything ignored, even the start mark
    write_reg(REG_FRAME, '0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    wait_idle();

    // Oversized frame acts as the store size; loading never completes here
    write_reg(REG_FRAME, '1);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'hAA, 1'b0);
    wait_idle();
    write_reg(REG_FRAME, CFG_DW'(MAX_PIX));
    push_pixel(8'h55, 1'b1);       // restart of an unfinished load
    push_pixel(8'hFF, 1'b0);
    wait_idle();

    // Aborted loads at random sizes, some with a restart in the middle
    repeat (3) begin
      write_reg(REG_FRAME, CFG_DW'($urandom_range(5, 40)));
      abort_n = $urandom_range(0, int'(frame_set) - 2);
      push_pixel(rand_pixel(), 1'b1);
      repeat (abort_n) push_pixel(rand_pixel(), 1'b0);
      if ($urandom_range(0, 1)) push_pixel(rand_pixel(), 1'b1);
      wait_idle();
    end

    // Full first frame fills the store and sets model_ready on its last pixel
    write_reg(REG_FRAME, CFG_DW'(LOAD_PIXELS));
    push_pixel(rand_pixel(), 1'b1);
    repeat (LOAD_PIXELS - 1) push_pixel(rand_pixel(), 1'b0);
    wait_idle();

    // Alpha of one: background follows the pixel; one pixel past the end
    write_reg(REG_FRAME, CFG_DW'(4));
    write_reg(REG_ALPHA, CFG_DW'(ALPHA_ONE));
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'h80, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'h7F, 1'b0);
    wait_idle();

    // Alpha above one with stray upper bits, on a short frame
    write_reg(REG_ALPHA, '1);
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    wait_idle();

    // Alpha zero: nothing moves
    write_reg(REG_ALPHA, '0);
    push_pixel(8'hFF, 1'b1);
    push_pixel(8'h00, 1'b0);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h00, 1'b0);
    wait_idle();

    // Half weight: exercises rounding of the blend and of the output
    write_reg(REG_ALPHA, CFG_DW'(32768));
    push_pixel(8'h00, 1'b1);
    push_pixel(8'hFF, 1'b0);
    push_pixel(8'h01, 1'b0);
    push_pixel(8'hFE, 1'b0);
    wait_idle();

    // Random part: frames of random content under changing settings
    rand_base = sent_n;
    while (sent_n - rand_base < RAND_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_reg(REG_ALPHA, pick_alpha());
      if ($urandom_range(0, 2) == 0) write_reg(REG_FRAME, pick_frame());
      repeat ($urandom_range(1, 5)) gen_frame(int'(frame_set));
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (error_n == 0 && bg_expected.size() == 0) begin
      $display("PASS running_average_background");
    end else begin
      $display("FAIL running_average_background");
    end
    $finish;
  end

endmodule
